@@ sv/dsk_pkg.sv @@
package dsk_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic REG_WINDOW_DELTA  = 1'b0;
  localparam logic REG_SEGMENT_THETA = 1'b1;

  localparam int CFG_W   = 7;
  localparam int KV_W    = 48;
  localparam int LARG_W  = 11;   // signed run length argument, covers L - 2*theta
  localparam int C3_W    = 22;
  localparam int C2_W    = 16;
  localparam int PART_W  = 18;
  localparam int PROD_W  = 25;
  localparam int TERM_W  = 26;
  localparam int TAB_N   = 258;  // run length terms reach window size + 1
  localparam logic [KV_W-1:0] KV_SAT = {KV_W{1'b1}};

  typedef logic [TAB_N-1:0][C3_W-1:0] c3_tab_t;
  typedef logic [TAB_N-1:0][C2_W-1:0] c2_tab_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PAIR,
    S_RD,
    S_CMP,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  // Build x choose 3 by running sums, no division needed
  function automatic c3_tab_t build_c3();
    c3_tab_t t;
    int c2v;
    int c3v;
    c2v = 0;
    c3v = 0;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = C3_W'(c3v);
      c3v  = c3v + c2v;
      c2v  = c2v + i;
    end
    return t;
  endfunction

  function automatic c2_tab_t build_c2();
    c2_tab_t t;
    int c2v;
    c2v = 0;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = C2_W'(c2v);
      c2v  = c2v + i;
    end
    return t;
  endfunction

  localparam c3_tab_t C3_TAB = build_c3();
  localparam c2_tab_t C2_TAB = build_c2();

  function automatic logic [C3_W-1:0] choose3(logic signed [LARG_W-1:0] x);
    logic [C3_W-1:0] r;
    r = '0;
    if (x >= 3) r = C3_TAB[x[8:0]];
    return r;
  endfunction

  function automatic logic [C2_W-1:0] choose2(logic signed [LARG_W-1:0] x);
    logic [C2_W-1:0] r;
    r = '0;
    if (x >= 2) r = C2_TAB[x[8:0]];
    return r;
  endfunction

endpackage

@@ sv/dsk_in_if.sv @@
interface dsk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] symbol;

  modport source (output valid, output cmd, output symbol, input ready);
  modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

@@ sv/dsk_out_if.sv @@
interface dsk_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] kernel_value;
  logic        empty_error;
  logic        overflow_flag;

  modport source (output valid, output kernel_value, output empty_error,
                  output overflow_flag, input ready);
  modport sink   (input valid, input kernel_value, input empty_error,
                  input overflow_flag, output ready);
endinterface

@@ sv/distant_segments_string_kernel_core.sv @@
// Distant-segments string kernel.
// req carries words {cmd, symbol}: cmd 0 appends symbol to string A, cmd 1 to
// string B, cmd 2 computes the kernel, emits one word on rsp and clears both
// strings; cmd 3 is taken and ignored. A load into a full string is dropped
// and flagged in the next result.
// A compute walks every position pair (p, q) one at a time through the single
// read port of each string memory: an unequal pair passes through S_PAIR, S_RD
// and S_CMP; an equal pair reads and compares n positions, n = min(len_a - p,
// len_b - q, delta), then passes S_FIN1 and S_FIN2. When a string is empty the
// compute goes from S_INIT straight to S_OUT.
// One sequencer and one run tracker are reused for every pair; binomial terms
// come from constant tables. req.ready is low during a compute.
// The finished word sits in an output register; loads are taken while it
// waits; the next compute runs but stops in S_OUT until it drains if rsp stalls.
// The user must write configuration (cfg_we, cfg_index, cfg_wdata) only while
// idle; the block does not enforce this. Synchronous reset empties both strings,
// clears the flags and sets window_delta to 1 and segment_theta to 0.
module distant_segments_string_kernel_core #(
  parameter int MAX_LEN   = 256,
  parameter int MAX_DELTA = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [dsk_pkg::CFG_W-1:0] cfg_wdata,
  dsk_in_if.sink                   req,
  dsk_out_if.source                rsp
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KW = $clog2(MAX_DELTA + 1);

  dsk_pkg::state_t state, state_next;

  logic [dsk_pkg::CFG_W-1:0] window_delta, segment_theta;
  logic [LW-1:0] length_a, length_b, p, q;
  logic          load_overflow, sat;
  logic [7:0]    mem_a [MAX_LEN];
  logic [7:0]    mem_b [MAX_LEN];
  logic [7:0]    rd_a, rd_b;
  logic [KW-1:0] n, k, r, span0;
  logic          in_run, first;
  logic signed [dsk_pkg::LARG_W-1:0] l0;
  logic [dsk_pkg::PART_W-1:0] part;
  logic [dsk_pkg::PROD_W-1:0] prod;
  logic [dsk_pkg::C3_W+1:0]   t3;
  logic [dsk_pkg::KV_W-1:0]   acc;

  logic [dsk_pkg::KV_W-1:0] o_kv;
  logic o_valid, o_empty, o_ovf;

  logic          acc_in, we_a, we_b;
  logic [AW-1:0] addr_a, addr_b;
  logic [KW-1:0] dlt, n_calc, r_eff;
  logic [LW-1:0] rem_a, rem_b, rem_ab;
  logic          match, close_run, last_pair, out_free;
  logic signed [dsk_pkg::LARG_W-1:0] th, cl_len;
  logic [dsk_pkg::PART_W-1:0] part_inc;
  logic [dsk_pkg::CFG_W-1:0] scale;
  logic [dsk_pkg::KV_W:0] acc_sum;

  assign req.ready = (state == dsk_pkg::S_IDLE);
  assign acc_in    = req.valid && req.ready;
  assign we_a      = acc_in && (req.cmd == dsk_pkg::CMD_LOAD_A) && (length_a < LW'(MAX_LEN));
  assign we_b      = acc_in && (req.cmd == dsk_pkg::CMD_LOAD_B) && (length_b < LW'(MAX_LEN));
  assign out_free  = !o_valid || rsp.ready;

  assign rsp.valid         = o_valid;
  assign rsp.kernel_value  = o_kv;
  assign rsp.empty_error   = o_empty;
  assign rsp.overflow_flag = o_ovf;

  // Clamp window size to 1..MAX_DELTA
  always_comb begin
    if (window_delta == '0) dlt = KW'(1);
    else if (int'(window_delta) > MAX_DELTA) dlt = KW'(MAX_DELTA);
    else dlt = KW'(window_delta);
  end

  // Window length for the current pair
  always_comb begin
    rem_a  = length_a - p;
    rem_b  = length_b - q;
    rem_ab = (rem_b < rem_a) ? rem_b : rem_a;
    n_calc = (int'(rem_ab) < int'(dlt)) ? KW'(rem_ab) : dlt;
  end

  assign addr_a    = AW'(p + LW'(k) - LW'(1));
  assign addr_b    = AW'(q + LW'(k) - LW'(1));
  assign last_pair = (q == length_b - LW'(1)) && (p == length_a - LW'(1));

  // Run tracker for the word just read
  assign match     = (rd_a == rd_b);
  assign r_eff     = match ? (in_run ? r + KW'(1) : KW'(1)) : r;
  assign close_run = (in_run && !match) || (match && k == n);
  assign th        = dsk_pkg::LARG_W'(segment_theta);
  assign cl_len    = dsk_pkg::LARG_W'(r_eff) + dsk_pkg::LARG_W'(1);
  assign part_inc  = dsk_pkg::PART_W'(dsk_pkg::choose2(cl_len))
                   - dsk_pkg::PART_W'(dsk_pkg::choose2(cl_len - th));
  assign scale     = (int'(segment_theta) < int'(span0)) ? segment_theta
                                                          : dsk_pkg::CFG_W'(span0);
  assign acc_sum   = {1'b0, acc}
                   + (dsk_pkg::KV_W+1)'(dsk_pkg::TERM_W'(t3) + dsk_pkg::TERM_W'(prod));

  // String memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_a) mem_a[length_a[AW-1:0]] <= req.symbol;
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[length_b[AW-1:0]] <= req.symbol;
    rd_b <= mem_b[addr_b];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= dsk_pkg::S_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dsk_pkg::S_IDLE: begin
        if (acc_in && req.cmd == dsk_pkg::CMD_COMPUTE) state_next = dsk_pkg::S_INIT;
      end
      dsk_pkg::S_INIT: begin
        if (length_a == '0 || length_b == '0) state_next = dsk_pkg::S_OUT;
        else state_next = dsk_pkg::S_PAIR;
      end
      dsk_pkg::S_PAIR: state_next = dsk_pkg::S_RD;
      dsk_pkg::S_RD:   state_next = dsk_pkg::S_CMP;
      dsk_pkg::S_CMP: begin
        if (k == KW'(1) && !match) state_next = last_pair ? dsk_pkg::S_OUT : dsk_pkg::S_PAIR;
        else if (k == n) state_next = dsk_pkg::S_FIN1;
        else state_next = dsk_pkg::S_RD;
      end
      dsk_pkg::S_FIN1: state_next = dsk_pkg::S_FIN2;
      dsk_pkg::S_FIN2: state_next = last_pair ? dsk_pkg::S_OUT : dsk_pkg::S_PAIR;
      dsk_pkg::S_OUT: begin
        if (out_free) state_next = dsk_pkg::S_IDLE;
      end
      default: state_next = dsk_pkg::S_IDLE;
    endcase
  end

  // Configuration and string lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      window_delta  <= dsk_pkg::CFG_W'(1);
      segment_theta <= '0;
      length_a      <= '0;
      length_b      <= '0;
      load_overflow <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == dsk_pkg::REG_WINDOW_DELTA) window_delta <= cfg_wdata;
      if (cfg_we && cfg_index == dsk_pkg::REG_SEGMENT_THETA) segment_theta <= cfg_wdata;
      if (we_a) length_a <= length_a + LW'(1);
      if (we_b) length_b <= length_b + LW'(1);
      if (acc_in && ((req.cmd == dsk_pkg::CMD_LOAD_A && !we_a) ||
                     (req.cmd == dsk_pkg::CMD_LOAD_B && !we_b)))
        load_overflow <= 1'b1;
      if (state == dsk_pkg::S_OUT && out_free) begin
        length_a      <= '0;
        length_b      <= '0;
        load_overflow <= 1'b0;
      end
    end
  end

  // Pair walk, run tracking and accumulation
  always_ff @(posedge clk) begin
    case (state)
      dsk_pkg::S_INIT: begin
        p   <= '0;
        q   <= '0;
        acc <= '0;
        sat <= 1'b0;
      end
      dsk_pkg::S_PAIR: begin
        n      <= n_calc;
        k      <= KW'(1);
        in_run <= 1'b0;
        first  <= 1'b1;
        part   <= '0;
        l0     <= '0;
        span0  <= '0;
      end
      dsk_pkg::S_CMP: begin
        r      <= r_eff;
        in_run <= match;
        k      <= k + KW'(1);
        if (close_run) begin
          if (first) begin
            l0    <= cl_len;
            span0 <= r_eff;
            first <= 1'b0;
          end else begin
            part <= part + part_inc;
          end
        end
        if (k == KW'(1) && !match) begin
          if (q == length_b - LW'(1)) begin
            q <= '0;
            p <= p + LW'(1);
          end else begin
            q <= q + LW'(1);
          end
        end
      end
      dsk_pkg::S_FIN1: begin
        t3   <= (dsk_pkg::C3_W+2)'(dsk_pkg::choose3(l0))
              + (dsk_pkg::C3_W+2)'(dsk_pkg::choose3(l0 - (th <<< 1)))
              - ((dsk_pkg::C3_W+2)'(dsk_pkg::choose3(l0 - th)) << 1);
        prod <= dsk_pkg::PROD_W'(scale) * dsk_pkg::PROD_W'(part);
      end
      dsk_pkg::S_FIN2: begin
        if (acc_sum > {1'b0, dsk_pkg::KV_SAT}) begin
          acc <= dsk_pkg::KV_SAT;
          sat <= 1'b1;
        end else begin
          acc <= acc_sum[dsk_pkg::KV_W-1:0];
        end
        if (q == length_b - LW'(1)) begin
          q <= '0;
          p <= p + LW'(1);
        end else begin
          q <= q + LW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      if (state == dsk_pkg::S_OUT && out_free) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dsk_pkg::S_OUT && out_free) begin
      o_empty <= (length_a == '0) || (length_b == '0);
      o_kv    <= ((length_a == '0) || (length_b == '0)) ? '0 : acc;
      o_ovf   <= load_overflow || (((length_a != '0) && (length_b != '0)) && sat);
    end
  end

endmodule

@@ tb/distant_segments_string_kernel_core_tb.sv @@
`timescale 1ns / 100ps

module distant_segments_string_kernel_core_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STR_DEPTH = 256;
  localparam int DELTA_CAP = 64;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [dsk_pkg::KV_W-1:0] KV_MAX = {dsk_pkg::KV_W{1'b1}};

  typedef struct packed {
    logic [dsk_pkg::KV_W-1:0] kv;
    logic            empty;
    logic            ovf;
  } kernel_word_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [7:0]   sym;
    bit           typed;
    kernel_word_t word;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [dsk_pkg::CFG_W-1:0] cfg_wdata;

  dsk_in_if  req ();
  dsk_out_if rsp ();

  distant_segments_string_kernel_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // Shadow copy of the block's strings and settings
  logic [7:0]  str_a [STR_DEPTH];
  logic [7:0]  str_b [STR_DEPTH];
  int          len_a;
  int          len_b;
  bit          drop_seen;
  logic [dsk_pkg::CFG_W-1:0] delta_reg;
  logic [dsk_pkg::CFG_W-1:0] theta_reg;

  kernel_word_t kernel_q [$];
  int  mismatches;
  longint cycles;
  bit  steady;
  bit  hold_rsp;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint c3(longint x);
    if (x < 3) return 0;
    return x * (x - 1) * (x - 2) / 6;
  endfunction

  function automatic longint c2(longint x);
    if (x < 2) return 0;
    return x * (x - 1) / 2;
  endfunction

  // Sum of the run terms for one equal position pair
  function automatic longint pair_contrib(int p, int q, int dlt, longint th);
    int n;
    int i;
    int st;
    bit first;
    longint l0;
    longint span0;
    longint part;
    longint ln;
    longint scale;
    n = len_a - p;
    if (len_b - q < n) n = len_b - q;
    if (dlt < n) n = dlt;
    i = 1;
    first = 1'b1;
    l0 = 0;
    span0 = 0;
    part = 0;
    while (i <= n) begin
      st = i;
      i++;
      while (i <= n && str_a[p + i - 1] == str_b[q + i - 1]) i++;
      ln = longint'(i - st) + 1;
      if (first) begin
        l0 = ln;
        span0 = i - st;
        first = 1'b0;
      end else begin
        part += c2(ln) - c2(ln - th);
      end
      i++;
      while (i <= n && str_a[p + i - 1] != str_b[q + i - 1]) i++;
    end
    scale = (th < span0) ? th : span0;
    return c3(l0) - 2 * c3(l0 - th) + c3(l0 - 2 * th) + scale * part;
  endfunction

  // Apply one accepted word to the shadow state; return 1 when a result follows
  function automatic bit apply_word(logic [1:0] cmd, logic [7:0] sym,
                                    output kernel_word_t res);
    int dlt;
    longint acc;
    bit sat;
    bit empty;
    res = '0;
    case (cmd)
      dsk_pkg::CMD_LOAD_A: begin
        if (len_a < STR_DEPTH) str_a[len_a++] = sym;
        else drop_seen = 1'b1;
        return 1'b0;
      end
      dsk_pkg::CMD_LOAD_B: begin
        if (len_b < STR_DEPTH) str_b[len_b++] = sym;
        else drop_seen = 1'b1;
        return 1'b0;
      end
      dsk_pkg::CMD_COMPUTE: begin
        dlt = delta_reg;
        if (dlt == 0) dlt = 1;
        if (dlt > DELTA_CAP) dlt = DELTA_CAP;
        acc = 0;
        sat = 1'b0;
        empty = (len_a == 0) || (len_b == 0);
        if (!empty) begin
          for (int p = 0; p < len_a; p++) begin
            for (int q = 0; q < len_b; q++) begin
              if (str_a[p] == str_b[q]) begin
                acc += pair_contrib(p, q, dlt, longint'(theta_reg));
                if (acc > longint'(KV_MAX)) begin
                  acc = longint'(KV_MAX);
                  sat = 1'b1;
                end
              end
            end
          end
        end
        res.kv = acc[dsk_pkg::KV_W-1:0];
        res.empty = empty;
        res.ovf = drop_seen || sat;
        len_a = 0;
        len_b = 0;
        drop_seen = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Offer one word, idling at random, until the block takes it
  task automatic send_word(logic [1:0] cmd, logic [7:0] sym, bit typed,
                           kernel_word_t typed_word);
    kernel_word_t res;
    while (!steady && $urandom_range(0, 99) < 31) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.cmd    <= cmd;
    req.symbol <= sym;
    do @(posedge clk); while (!req.ready);
    if (apply_word(cmd, sym, res)) kernel_q.push_back(typed ? typed_word : res);
  endtask

  task automatic drain_and_rest();
    while (kernel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [dsk_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dsk_pkg::REG_WINDOW_DELTA) delta_reg = val;
    else theta_reg = val;
  endtask

  // Well-formed job: random loads (a string may stay empty), then compute
  task automatic random_job(output int n_items);
    int la;
    int lb;
    int k;
    logic [7:0] base;
    kernel_word_t none;
    none = '0;
    n_items = 0;
    la = ($urandom_range(0, 99) < 10) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    lb = ($urandom_range(0, 99) < 10) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    if ($urandom_range(0, 99) < 4) la = 0;
    if ($urandom_range(0, 99) < 4) lb = 0;
    k = ($urandom_range(0, 99) < 15) ? 256 : $urandom_range(1, 4);
    base = 8'($urandom_range(0, 255));
    while (la + lb > 0) begin
      if ($urandom_range(0, 99) < 3) begin
        send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, none);
        n_items++;
      end
      if (la > 0 && (lb == 0 || $urandom_range(0, 1))) begin
        send_word(dsk_pkg::CMD_LOAD_A, base + 8'($urandom_range(0, k - 1)), 1'b0, none);
        la--;
      end else begin
        send_word(dsk_pkg::CMD_LOAD_B, base + 8'($urandom_range(0, k - 1)), 1'b0, none);
        lb--;
      end
      n_items++;
    end
    send_word(dsk_pkg::CMD_COMPUTE, 8'($urandom_range(0, 255)), 1'b0, none);
    n_items++;
  endtask

  // Directed words; typed results only where obvious
  dir_row_t dir_rows [] = '{
    '{dsk_pkg::CMD_COMPUTE, 8'h00, 1'b1, '{48'd0, 1'b1, 1'b0}},
    '{dsk_pkg::CMD_LOAD_A,  8'hFF, 1'b0, '0},
    '{dsk_pkg::CMD_COMPUTE, 8'hFF, 1'b1, '{48'd0, 1'b1, 1'b0}},
    '{dsk_pkg::CMD_LOAD_B,  8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_COMPUTE, 8'h5A, 1'b1, '{48'd0, 1'b1, 1'b0}},
    '{CMD_UNUSED,           8'hAA, 1'b0, '0},
    '{CMD_UNUSED,           8'h55, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_A,  8'h55, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_B,  8'h55, 1'b0, '0},
    '{dsk_pkg::CMD_COMPUTE, 8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_A,  8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_A,  8'hFF, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_A,  8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_B,  8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_B,  8'hFF, 1'b0, '0},
    '{dsk_pkg::CMD_LOAD_B,  8'h00, 1'b0, '0},
    '{dsk_pkg::CMD_COMPUTE, 8'h00, 1'b0, '0}
  };

  // Settings per phase: extremes, out-of-range values, ordinary values
  logic [dsk_pkg::CFG_W-1:0] phase_delta [] =
    '{7'd64, 7'd0, 7'd127, 7'd3, 7'd8, 7'd1, 7'd20};
  logic [dsk_pkg::CFG_W-1:0] phase_theta [] =
    '{7'd1, 7'd127, 7'd0, 7'd64, 7'd2, 7'd3, 7'd5};

  // Stimulus
  initial begin
    kernel_word_t none;
    int n;
    int done;
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = dsk_pkg::REG_WINDOW_DELTA;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.cmd = dsk_pkg::CMD_LOAD_A;
    req.symbol = '0;
    steady = 1'b0;
    hold_rsp = 1'b0;
    mismatches = 0;
    len_a = 0;
    len_b = 0;
    drop_seen = 1'b0;
    delta_reg = 7'd1;
    theta_reg = 7'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].word);

    // Overfill A, then B: extra symbols dropped and flagged
    for (int i = 0; i < STR_DEPTH + 2; i++)
      send_word(dsk_pkg::CMD_LOAD_A, 8'($urandom_range(0, 255)), 1'b0, none);
    send_word(dsk_pkg::CMD_LOAD_B, 8'($urandom_range(0, 255)), 1'b0, none);
    send_word(dsk_pkg::CMD_COMPUTE, 8'h00, 1'b0, none);
    send_word(dsk_pkg::CMD_LOAD_A, 8'($urandom_range(0, 255)), 1'b0, none);
    for (int i = 0; i < STR_DEPTH + 1; i++)
      send_word(dsk_pkg::CMD_LOAD_B, 8'($urandom_range(0, 255)), 1'b0, none);
    send_word(dsk_pkg::CMD_COMPUTE, 8'h00, 1'b0, none);
    req.valid <= 1'b0;
    drain_and_rest();

    foreach (phase_delta[ph]) begin
      write_reg(dsk_pkg::REG_WINDOW_DELTA, phase_delta[ph]);
      write_reg(dsk_pkg::REG_SEGMENT_THETA, phase_theta[ph]);
      steady = (ph == 2);
      if (ph == 3) hold_rsp = 1'b1;
      done = 0;
      while (done < 44) begin
        random_job(n);
        done += n;
      end
      steady = 1'b0;
      req.valid <= 1'b0;
      drain_and_rest();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Result side readiness with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_rsp) begin
      hold_rsp = 1'b0;
      rsp.ready <= 1'b0;
      repeat (400) @(posedge clk);
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare each returned word with the oldest expectation
  always @(posedge clk) begin
    kernel_word_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (kernel_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = kernel_q.pop_front();
        if (rsp.kernel_value !== want.kv)
          report($sformatf("kernel_value %0d, want %0d", rsp.kernel_value, want.kv));
        if (rsp.empty_error !== want.empty)
          report($sformatf("empty_error %b, want %b", rsp.empty_error, want.empty));
        if (rsp.overflow_flag !== want.ovf)
          report($sformatf("overflow_flag %b, want %b", rsp.overflow_flag, want.ovf));
      end
    end
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout, %0d words still expected", kernel_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
